// ===== sv/cbad_pkg.sv =====
package cbad_pkg;

  // Bus operation codes
  localparam logic [1:0] OpRead  = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpLoad  = 2'd2;

  // Result target codes
  localparam logic [2:0] TgtWram = 3'd0;
  localparam logic [2:0] TgtPpu  = 3'd1;
  localparam logic [2:0] TgtApu  = 3'd2;
  localparam logic [2:0] TgtPram = 3'd3;
  localparam logic [2:0] TgtRom  = 3'd4;
  localparam logic [2:0] TgtDma  = 3'd5;
  localparam logic [2:0] TgtErr  = 3'd6;

  // DMA source codes
  localparam logic [1:0] DmaWram = 2'd0;
  localparam logic [1:0] DmaPram = 2'd1;
  localparam logic [1:0] DmaRom  = 2'd2;

  // Memory map
  localparam logic [15:0] AddrPpuLo  = 16'h2000;
  localparam logic [15:0] AddrApuLo  = 16'h4000;
  localparam logic [15:0] AddrDmaReg = 16'h4014;
  localparam logic [15:0] AddrApuHi  = 16'h4020;
  localparam logic [15:0] AddrPramLo = 16'h6000;
  localparam logic [15:0] AddrRomLo  = 16'h8000;
  localparam logic [15:0] AddrRomHi  = 16'hC000;

  localparam int WorkRamBytes = 2048;
  localparam int WorkRamAw    = $clog2(WorkRamBytes);
  localparam int SaveRamBytes = 8192;
  localparam int SaveRamAw    = $clog2(SaveRamBytes);
  localparam int ApuBytes     = 33;
  localparam int ApuAw        = $clog2(ApuBytes);
  localparam int MemAw        = 15;

  localparam logic [9:0] DmaStallBase = 10'd513;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_WRAM,
    MEM_PRAM,
    MEM_APU,
    MEM_ROM
  } mem_e;

  // One classified item, as it travels from front to back
  typedef struct packed {
    mem_e             mem;
    logic             we;
    logic [MemAw-1:0] maddr;
    logic [7:0]       wdata;
    logic [2:0]       target;
    logic [2:0]       preg;
    logic [1:0]       dsrc;
    logic [14:0]      doff;
    logic [9:0]       stall;
  } item_t;

  // One result item
  typedef struct packed {
    logic [7:0]  rdata;
    logic [2:0]  target;
    logic [2:0]  preg;
    logic [1:0]  dsrc;
    logic [14:0] doff;
    logic [9:0]  stall;
  } result_t;

endpackage

// ===== sv/cpu_bus_address_decoder.sv =====
// CPU bus address decoder for a fixed-bank cartridge map. Each item is one
// bus access (read, write or PRG ROM byte load), taken at a clock edge with
// start_i high and busy_o low; its result shows on the result ports for one
// cycle with done_o high, in acceptance order.
// The receiver cannot hold results off, and none is ever dropped. The block
// sustains one item per clock: the front decodes the address map and pushes
// the classified item into a two-entry queue, and the back pops one item per
// cycle and runs it against the memories; the item is registered in the queue,
// then in the memories' registered read ports and the result register.
// Since the back never waits, busy_o stays low in normal
// use. Work RAM (2 KB, mirrored below 0x2000), PRG RAM (8 KB at 0x6000), the
// 33 APU bytes and the PRG ROM are plain RAMs with no reset and no clearing
// pass; reading a byte never written returns an undefined value. Load the ROM
// with load items before reading it. Write rom_is_16k only while idle.
module cpu_bus_address_decoder #(
  parameter int ROM_BYTES = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  wdata_i,
  input  logic        cycle_odd_i,
  input  logic [14:0] rom_load_index_i,
  // configuration
  input  logic        rom_is_16k_we_i,
  input  logic        rom_is_16k_i,
  // results
  output logic        done_o,
  output logic [7:0]  rdata_o,
  output logic [2:0]  target_o,
  output logic [2:0]  ppu_reg_o,
  output logic [1:0]  dma_from_rom_o,
  output logic [14:0] dma_offset_o,
  output logic [9:0]  stall_cycles_o
);

  import cbad_pkg::*;

  logic    rom_is_16k_q, rom_is_16k_d;
  logic    q_full, q_empty, q_push, q_pop;
  item_t   push_item, pop_item;
  result_t result;

  // Hold the ROM size select until the next write
  assign rom_is_16k_d = rom_is_16k_we_i ? rom_is_16k_i : rom_is_16k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_is_16k_q <= 1'b0;
    end else begin
      rom_is_16k_q <= rom_is_16k_d;
    end
  end

  // Front: accept and classify
  cbad_front #(.ROM_BYTES(ROM_BYTES)) u_front (
    .start_i          (start_i),
    .full_i           (q_full),
    .rom_is_16k_i     (rom_is_16k_q),
    .op_i             (op_i),
    .addr_i           (addr_i),
    .wdata_i          (wdata_i),
    .cycle_odd_i      (cycle_odd_i),
    .rom_load_index_i (rom_load_index_i),
    .busy_o           (busy_o),
    .push_o           (q_push),
    .item_o           (push_item)
  );

  // Queue between decode and memory access
  cbad_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .item_o  (pop_item)
  );

  // Back: memory access and result
  cbad_back #(.ROM_BYTES(ROM_BYTES)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (q_empty),
    .item_i   (pop_item),
    .pop_o    (q_pop),
    .done_o   (done_o),
    .result_o (result)
  );

  assign rdata_o        = result.rdata;
  assign target_o       = result.target;
  assign ppu_reg_o      = result.preg;
  assign dma_from_rom_o = result.dsrc;
  assign dma_offset_o   = result.doff;
  assign stall_cycles_o = result.stall;

  // Every accepted item comes out, through the queue slot and then the read registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("accepted item did not produce a result in time");

  // A result only follows an item taken from the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(q_pop))
    else $error("result without a popped item");

  // Stall is reported only for a DMA, and then is 513 or 514
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((target_o == TgtDma) ?
                (stall_cycles_o == DmaStallBase ||
                 stall_cycles_o == DmaStallBase + 10'd1) :
                (stall_cycles_o == 10'd0)))
    else $error("stall cycles inconsistent with target");

  // The back drains every cycle, so the queue never fills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_full)
    else $error("decode queue filled up");

endmodule

// ===== sv/cbad_ram.sv =====
module cbad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== sv/cbad_front.sv =====
module cbad_front #(
  parameter int ROM_BYTES = 32768
) (
  input  logic              start_i,
  input  logic              full_i,
  input  logic              rom_is_16k_i,
  input  logic [1:0]        op_i,
  input  logic [15:0]       addr_i,
  input  logic [7:0]        wdata_i,
  input  logic              cycle_odd_i,
  input  logic [14:0]       rom_load_index_i,
  output logic              busy_o,
  output logic              push_o,
  output cbad_pkg::item_t   item_o
);

  import cbad_pkg::*;

  // Fold an offset below twice the ROM size into the ROM
  function automatic logic [14:0] rom_wrap(input logic [15:0] off);
    logic [15:0] res;
    res = off;
    if (off >= 16'(ROM_BYTES)) begin
      res = off - 16'(ROM_BYTES);
    end
    return res[14:0];
  endfunction

  function automatic logic [14:0] rom_index(input logic [15:0] a, input logic is16k);
    logic [15:0] off;
    if (is16k && a >= AddrRomHi) begin
      off = a - AddrRomHi;
    end else begin
      off = a - AddrRomLo;
    end
    return rom_wrap(off);
  endfunction

  logic [15:0] page;

  assign busy_o = full_i;
  assign push_o = start_i && !full_i;
  assign page   = {wdata_i, 8'h00};

  always_comb begin
    item_o        = '0;
    item_o.mem    = MEM_NONE;
    item_o.wdata  = wdata_i;
    item_o.target = TgtErr;
    unique case (op_i)
      OpRead: begin
        priority if (addr_i < AddrPpuLo) begin
          item_o.mem    = MEM_WRAM;
          item_o.maddr  = MemAw'(addr_i[WorkRamAw-1:0]);
          item_o.target = TgtWram;
        end else if (addr_i < AddrApuLo) begin
          item_o.target = TgtPpu;
          item_o.preg   = addr_i[2:0];
        end else if (addr_i <= AddrApuHi) begin
          item_o.mem    = MEM_APU;
          item_o.maddr  = MemAw'(addr_i[ApuAw-1:0]);
          item_o.target = TgtApu;
        end else if (addr_i < AddrPramLo) begin
          item_o.target = TgtErr;
        end else if (addr_i < AddrRomLo) begin
          item_o.mem    = MEM_PRAM;
          item_o.maddr  = MemAw'(addr_i[SaveRamAw-1:0]);
          item_o.target = TgtPram;
        end else begin
          item_o.mem    = MEM_ROM;
          item_o.maddr  = rom_index(addr_i, rom_is_16k_i);
          item_o.target = TgtRom;
        end
      end
      OpWrite: begin
        priority if (addr_i < AddrPpuLo) begin
          item_o.mem    = MEM_WRAM;
          item_o.we     = 1'b1;
          item_o.maddr  = MemAw'(addr_i[WorkRamAw-1:0]);
          item_o.target = TgtWram;
        end else if (addr_i < AddrApuLo) begin
          item_o.target = TgtPpu;
          item_o.preg   = addr_i[2:0];
        end else if (addr_i == AddrDmaReg) begin
          // Sprite DMA: report the page source, nothing is stored
          priority if (page < AddrPpuLo) begin
            item_o.dsrc   = DmaWram;
            item_o.doff   = 15'(page[WorkRamAw-1:0]);
            item_o.target = TgtDma;
          end else if (page < AddrPramLo) begin
            item_o.target = TgtErr;
          end else if (page < AddrRomLo) begin
            item_o.dsrc   = DmaPram;
            item_o.doff   = 15'(page[SaveRamAw-1:0]);
            item_o.target = TgtDma;
          end else begin
            item_o.dsrc   = DmaRom;
            item_o.doff   = rom_index(page, rom_is_16k_i);
            item_o.target = TgtDma;
          end
          if (item_o.target == TgtDma) begin
            item_o.stall = DmaStallBase + {9'd0, cycle_odd_i};
          end
        end else if (addr_i <= AddrApuHi) begin
          item_o.mem    = MEM_APU;
          item_o.we     = 1'b1;
          item_o.maddr  = MemAw'(addr_i[ApuAw-1:0]);
          item_o.target = TgtApu;
        end else if (addr_i >= AddrPramLo && addr_i < AddrRomLo) begin
          item_o.mem    = MEM_PRAM;
          item_o.we     = 1'b1;
          item_o.maddr  = MemAw'(addr_i[SaveRamAw-1:0]);
          item_o.target = TgtPram;
        end else begin
          item_o.target = TgtErr;
        end
      end
      OpLoad: begin
        item_o.mem    = MEM_ROM;
        item_o.we     = 1'b1;
        item_o.maddr  = rom_wrap({1'b0, rom_load_index_i});
        item_o.target = TgtRom;
      end
      default: begin
        item_o.target = TgtErr;
      end
    endcase
  end

endmodule

// ===== sv/cbad_queue.sv =====
module cbad_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cbad_pkg::item_t item_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output cbad_pkg::item_t item_o
);

  import cbad_pkg::*;

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== sv/cbad_back.sv =====
module cbad_back #(
  parameter int ROM_BYTES = 32768
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  cbad_pkg::item_t   item_i,
  output logic              pop_o,
  output logic              done_o,
  output cbad_pkg::result_t result_o
);

  import cbad_pkg::*;

  localparam int RomAw = $clog2(ROM_BYTES);

  item_t      meta_q;
  logic       valid_q;
  logic [7:0] wram_rd, pram_rd, apu_rd, rom_rd;
  logic       wram_we, pram_we, apu_we, rom_we;
  logic [7:0] rd_sel;

  // Drain one item every cycle: the receiver never stalls
  assign pop_o = !empty_i;

  assign wram_we = pop_o && item_i.we && (item_i.mem == MEM_WRAM);
  assign pram_we = pop_o && item_i.we && (item_i.mem == MEM_PRAM);
  assign apu_we  = pop_o && item_i.we && (item_i.mem == MEM_APU);
  assign rom_we  = pop_o && item_i.we && (item_i.mem == MEM_ROM);

  cbad_ram #(.WIDTH(8), .DEPTH(WorkRamBytes)) u_wram (
    .clk_i   (clk_i),
    .we_i    (wram_we),
    .addr_i  (item_i.maddr[WorkRamAw-1:0]),
    .wdata_i (item_i.wdata),
    .rdata_o (wram_rd)
  );

  cbad_ram #(.WIDTH(8), .DEPTH(SaveRamBytes)) u_pram (
    .clk_i   (clk_i),
    .we_i    (pram_we),
    .addr_i  (item_i.maddr[SaveRamAw-1:0]),
    .wdata_i (item_i.wdata),
    .rdata_o (pram_rd)
  );

  cbad_ram #(.WIDTH(8), .DEPTH(ApuBytes)) u_apu (
    .clk_i   (clk_i),
    .we_i    (apu_we),
    .addr_i  (item_i.maddr[ApuAw-1:0]),
    .wdata_i (item_i.wdata),
    .rdata_o (apu_rd)
  );

  cbad_ram #(.WIDTH(8), .DEPTH(ROM_BYTES)) u_rom (
    .clk_i   (clk_i),
    .we_i    (rom_we),
    .addr_i  (item_i.maddr[RomAw-1:0]),
    .wdata_i (item_i.wdata),
    .rdata_o (rom_rd)
  );

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      meta_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= pop_o;
    end
  end

  assign done_o   = valid_q;
  assign result_o = {rd_sel, meta_q.target, meta_q.preg, meta_q.dsrc, meta_q.doff,
                     meta_q.stall};

  always_comb begin
    rd_sel = 8'h00;
    if (!meta_q.we) begin
      unique case (meta_q.mem)
        MEM_WRAM: rd_sel = wram_rd;
        MEM_PRAM: rd_sel = pram_rd;
        MEM_APU:  rd_sel = apu_rd;
        MEM_ROM:  rd_sel = rom_rd;
        default:  rd_sel = 8'h00;
      endcase
    end
  end

endmodule

// ===== bench/tb_cpu_bus_address_decoder.sv =====
module tb_cpu_bus_address_decoder;
  import cbad_pkg::*;

  // Op code 3 is not a defined access; the block answers it as an error.
  localparam logic [1:0] OpIgnored = 2'd3;
  localparam int RomBytes    = 32768;
  // Give up after this many cycles with no item and no result moving.
  localparam int QuietLimit  = 1000;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        odd;
    logic [14:0] li;
  } bus_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  op_i;
  logic [15:0] addr_i;
  logic [7:0]  wdata_i;
  logic        cycle_odd_i;
  logic [14:0] rom_load_index_i;
  logic        rom_is_16k_we_i;
  logic        rom_is_16k_i;
  logic        done_o;
  logic [7:0]  rdata_o;
  logic [2:0]  target_o;
  logic [2:0]  ppu_reg_o;
  logic [1:0]  dma_from_rom_o;
  logic [14:0] dma_offset_o;
  logic [9:0]  stall_cycles_o;

  cpu_bus_address_decoder DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .op_i             (op_i),
    .addr_i           (addr_i),
    .wdata_i          (wdata_i),
    .cycle_odd_i      (cycle_odd_i),
    .rom_load_index_i (rom_load_index_i),
    .rom_is_16k_we_i  (rom_is_16k_we_i),
    .rom_is_16k_i     (rom_is_16k_i),
    .done_o           (done_o),
    .rdata_o          (rdata_o),
    .target_o         (target_o),
    .ppu_reg_o        (ppu_reg_o),
    .dma_from_rom_o   (dma_from_rom_o),
    .dma_offset_o     (dma_offset_o),
    .stall_cycles_o   (stall_cycles_o)
  );

  // Items waiting to be driven, and decoded results waiting to come out.
  bus_item_t pending_accesses[$];
  result_t   decoded_q[$];

  // Mirror of the block's memories and of its ROM size setting.
  logic [7:0] m_wram [WorkRamBytes];
  logic [7:0] m_save [SaveRamBytes];
  logic [7:0] m_apu  [ApuBytes];
  logic [7:0] m_rom  [RomBytes];
  logic       mode_16k;

  // Which bytes the stimulus has written so far: reads only go to these.
  bit gw_wram [WorkRamBytes];
  bit gw_save [SaveRamBytes];
  bit gw_apu  [ApuBytes];
  bit gw_rom  [RomBytes];
  int gl_wram[$];
  int gl_save[$];
  int gl_apu[$];
  int gl_rom[$];

  int fail_count = 0;
  int quiet_cycles = 0;
  int idle_left = 0;
  bit gaps_on = 1'b1;
  logic item_taken = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ROM position of a bus address at or above 0x8000.
  function automatic logic [14:0] rom_pos(logic [15:0] a, logic c16);
    logic [15:0] off;
    off = (c16 && a >= AddrRomHi) ? a - AddrRomHi : a - AddrRomLo;
    return off[14:0];
  endfunction

  // Work out the result of one access and apply its side effects.
  function automatic result_t decode_access(bus_item_t it);
    result_t     r;
    logic [15:0] a;
    logic [15:0] page;
    r = '0;
    r.target = TgtErr;
    a = it.addr;
    case (it.op)
      OpRead: begin
        if (a < AddrPpuLo) begin
          r.rdata = m_wram[a % WorkRamBytes];
          r.target = TgtWram;
        end else if (a < AddrApuLo) begin
          r.target = TgtPpu;
          r.preg = a[2:0];
        end else if (a <= AddrApuHi) begin
          r.rdata = m_apu[a - AddrApuLo];
          r.target = TgtApu;
        end else if (a < AddrPramLo) begin
          r.target = TgtErr;
        end else if (a < AddrRomLo) begin
          r.rdata = m_save[a - AddrPramLo];
          r.target = TgtPram;
        end else begin
          r.rdata = m_rom[rom_pos(a, mode_16k)];
          r.target = TgtRom;
        end
      end
      OpWrite: begin
        if (a < AddrPpuLo) begin
          m_wram[a % WorkRamBytes] = it.wdata;
          r.target = TgtWram;
        end else if (a < AddrApuLo) begin
          r.target = TgtPpu;
          r.preg = a[2:0];
        end else if (a == AddrDmaReg) begin
          page = {it.wdata, 8'h00};
          if (page < AddrPpuLo) begin
            r.dsrc = DmaWram;
            r.doff = 15'(page % WorkRamBytes);
            r.target = TgtDma;
          end else if (page < AddrPramLo) begin
            r.target = TgtErr;
          end else if (page < AddrRomLo) begin
            r.dsrc = DmaPram;
            r.doff = 15'(page - AddrPramLo);
            r.target = TgtDma;
          end else begin
            r.dsrc = DmaRom;
            r.doff = rom_pos(page, mode_16k);
            r.target = TgtDma;
          end
          if (r.target == TgtDma) r.stall = DmaStallBase + {9'd0, it.odd};
        end else if (a <= AddrApuHi) begin
          m_apu[a - AddrApuLo] = it.wdata;
          r.target = TgtApu;
        end else if (a >= AddrPramLo && a < AddrRomLo) begin
          m_save[a - AddrPramLo] = it.wdata;
          r.target = TgtPram;
        end
      end
      OpLoad: begin
        m_rom[it.li] = it.wdata;
        r.target = TgtRom;
      end
      default: ;
    endcase
    return r;
  endfunction

  // True when a read of this address never touches an unwritten byte.
  function automatic bit read_ok(logic [15:0] a, logic c16);
    if (a < AddrPpuLo) return gw_wram[a % WorkRamBytes];
    if (a < AddrApuLo) return 1'b1;
    if (a <= AddrApuHi) return gw_apu[a - AddrApuLo];
    if (a < AddrPramLo) return 1'b1;
    if (a < AddrRomLo) return gw_save[a - AddrPramLo];
    return gw_rom[rom_pos(a, c16)];
  endfunction

  // Queue one item and note which byte it stores, if any.
  task automatic push_item(logic [1:0] op, logic [15:0] a, logic [7:0] wd, logic odd,
                           logic [14:0] li);
    bus_item_t it;
    int        i;
    it = '{op: op, addr: a, wdata: wd, odd: odd, li: li};
    if (op == OpLoad) begin
      i = li;
      if (!gw_rom[i]) begin gw_rom[i] = 1'b1; gl_rom.push_back(i); end
    end else if (op == OpWrite) begin
      if (a < AddrPpuLo) begin
        i = a % WorkRamBytes;
        if (!gw_wram[i]) begin gw_wram[i] = 1'b1; gl_wram.push_back(i); end
      end else if (a >= AddrApuLo && a <= AddrApuHi && a != AddrDmaReg) begin
        i = a - AddrApuLo;
        if (!gw_apu[i]) begin gw_apu[i] = 1'b1; gl_apu.push_back(i); end
      end else if (a >= AddrPramLo && a < AddrRomLo) begin
        i = a - AddrPramLo;
        if (!gw_save[i]) begin gw_save[i] = 1'b1; gl_save.push_back(i); end
      end
    end
    pending_accesses.push_back(it);
  endtask

  // One random access: mostly stores and reads of stored bytes, some DMA,
  // some raw addresses, a little op-3 noise.
  task automatic gen_random(logic c16);
    int          r;
    int          idx;
    logic [1:0]  op;
    logic [15:0] a;
    logic [7:0]  wd;
    logic        odd;
    logic [14:0] li;
    wd = 8'($urandom);
    odd = 1'($urandom);
    li = 15'($urandom);
    a = 16'($urandom);
    op = OpRead;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      op = OpLoad;
      // Favor the low half in 16 KB mode so mirrored reads find data.
      if (c16 && $urandom_range(0, 3) != 0) li[14] = 1'b0;
    end else if (r < 32) begin
      op = OpWrite;
      case ($urandom_range(0, 3))
        0: a = {3'b000, a[12:0]};
        1: a = AddrApuLo + 16'($urandom_range(0, ApuBytes - 1));
        2: a = AddrPramLo + {3'b000, a[12:0]};
        default: ;
      endcase
    end else if (r < 67) begin
      case ($urandom_range(0, 3))
        0: if (gl_wram.size() > 0)
             a = 16'(gl_wram[$urandom_range(0, gl_wram.size() - 1)] +
                     'h800 * $urandom_range(0, 3));
        1: if (gl_apu.size() > 0)
             a = AddrApuLo + 16'(gl_apu[$urandom_range(0, gl_apu.size() - 1)]);
        2: if (gl_save.size() > 0)
             a = AddrPramLo + 16'(gl_save[$urandom_range(0, gl_save.size() - 1)]);
        default: if (gl_rom.size() > 0) begin
          idx = gl_rom[$urandom_range(0, gl_rom.size() - 1)];
          if (c16 && idx < RomBytes / 2 && $urandom_range(0, 1) == 1) a = AddrRomHi + 16'(idx);
          else a = AddrRomLo + 16'(idx);
        end
      endcase
      if (!read_ok(a, c16)) a = AddrPpuLo + {3'b000, a[12:0]};
    end else if (r < 77) begin
      op = OpWrite;
      a = AddrDmaReg;
    end else if (r < 95) begin
      op = ($urandom_range(0, 1) == 1) ? OpWrite : OpRead;
      if (op == OpRead && !read_ok(a, c16)) a = AddrPpuLo + {3'b000, a[12:0]};
    end else begin
      op = OpIgnored;
    end
    push_item(op, a, wd, odd, li);
  endtask

  // Hold until every queued item has gone in and every result has come out.
  task automatic wait_drained;
    do begin
      @(negedge clk_i);
      #1;
    end while (pending_accesses.size() != 0 || start_i || decoded_q.size() != 0);
  endtask

  // Write the ROM size register; only called with the block idle.
  task automatic set_rom_mode(logic v);
    @(negedge clk_i);
    rom_is_16k_i <= v;
    rom_is_16k_we_i <= 1'b1;
    @(negedge clk_i);
    rom_is_16k_we_i <= 1'b0;
  endtask

  // Driver: at each falling edge hold an item that is not yet taken, else
  // idle out a gap burst, else put the next pending item on the ports.
  always @(negedge clk_i) begin : driver
    bus_item_t it;
    if (rst_ni && !(start_i && !item_taken)) begin
      if (idle_left > 0) begin
        start_i <= 1'b0;
        idle_left--;
      end else if (pending_accesses.size() > 0) begin
        it = pending_accesses.pop_front();
        op_i <= it.op;
        addr_i <= it.addr;
        wdata_i <= it.wdata;
        cycle_odd_i <= it.odd;
        rom_load_index_i <= it.li;
        start_i <= 1'b1;
        if (gaps_on && $urandom_range(0, 3) == 0) idle_left = $urandom_range(1, 15);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Monitor: at each rising edge check a strobed result against the oldest
  // expectation, then predict the item accepted at this same edge.
  always @(posedge clk_i) begin : monitor
    result_t want;
    bus_item_t it;
    item_taken <= (start_i === 1'b1) && (busy_o === 1'b0);
    if (rst_ni) begin
      if (rom_is_16k_we_i) mode_16k = rom_is_16k_i;
      if (done_o === 1'b1) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, got target %0h",
                   $time, target_o);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          check_field("rdata", 32'(want.rdata), 32'(rdata_o));
          check_field("target", 32'(want.target), 32'(target_o));
          check_field("ppu_reg", 32'(want.preg), 32'(ppu_reg_o));
          check_field("dma_from_rom", 32'(want.dsrc), 32'(dma_from_rom_o));
          check_field("dma_offset", 32'(want.doff), 32'(dma_offset_o));
          check_field("stall_cycles", 32'(want.stall), 32'(stall_cycles_o));
        end
      end
      if (start_i === 1'b1 && busy_o === 1'b0) begin
        it = '{op: op_i, addr: addr_i, wdata: wdata_i, odd: cycle_odd_i,
               li: rom_load_index_i};
        decoded_q.push_back(decode_access(it));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i === 1'b1 && busy_o === 1'b0) || done_o === 1'b1) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    start_i = 1'b0;
    op_i = OpRead;
    addr_i = '0;
    wdata_i = '0;
    cycle_odd_i = 1'b0;
    rom_load_index_i = '0;
    rom_is_16k_we_i = 1'b0;
    rom_is_16k_i = 1'b0;
    mode_16k = 1'b0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, 32 KB mode from reset: region edges, work RAM mirrors,
    // PPU index, unmapped ranges, every DMA source and the DMA gap.
    push_item(OpWrite, 16'h0000, 8'h00, 1'b0, 15'h0000);
    push_item(OpWrite, 16'h07FF, 8'hFF, 1'b1, 15'h7FFF);
    push_item(OpRead,  16'h1FFF, 8'h00, 1'b0, 15'h0000);
    push_item(OpRead,  16'h0800, 8'hFF, 1'b1, 15'h7FFF);
    push_item(OpRead,  16'h2000, 8'h00, 1'b0, 15'h0000);
    push_item(OpWrite, 16'h3FFF, 8'h3C, 1'b0, 15'h0000);
    push_item(OpWrite, AddrApuLo, 8'hA5, 1'b0, 15'h0000);
    push_item(OpWrite, AddrApuHi, 8'h5A, 1'b0, 15'h0000);
    push_item(OpRead,  AddrApuLo, 8'h00, 1'b0, 15'h0000);
    push_item(OpRead,  AddrApuHi, 8'h00, 1'b0, 15'h0000);
    push_item(OpRead,  16'h4021, 8'h00, 1'b0, 15'h0000);
    push_item(OpWrite, 16'h5FFF, 8'h11, 1'b0, 15'h0000);
    push_item(OpWrite, AddrRomLo, 8'h22, 1'b0, 15'h0000);
    push_item(OpWrite, 16'hFFFF, 8'h33, 1'b0, 15'h0000);
    push_item(OpWrite, AddrPramLo, 8'h81, 1'b0, 15'h0000);
    push_item(OpWrite, 16'h7FFF, 8'h7E, 1'b0, 15'h0000);
    push_item(OpRead,  AddrPramLo, 8'h00, 1'b0, 15'h0000);
    push_item(OpRead,  16'h7FFF, 8'h00, 1'b0, 15'h0000);
    push_item(OpLoad,  16'h0000, 8'hC3, 1'b0, 15'h0000);
    push_item(OpLoad,  16'hFFFF, 8'h3C, 1'b1, 15'h7FFF);
    push_item(OpRead,  AddrRomLo, 8'h00, 1'b0, 15'h0000);
    push_item(OpRead,  16'hFFFF, 8'h00, 1'b0, 15'h0000);
    push_item(OpWrite, AddrDmaReg, 8'h00, 1'b0, 15'h0000);
    push_item(OpWrite, AddrDmaReg, 8'h20, 1'b1, 15'h0000);
    push_item(OpWrite, AddrDmaReg, 8'h60, 1'b1, 15'h0000);
    push_item(OpWrite, AddrDmaReg, 8'hFF, 1'b1, 15'h0000);
    push_item(OpIgnored, 16'h0000, 8'h00, 1'b0, 15'h0000);
    wait_drained();

    // 16 KB mode: check the mirror at 0xC000, then random items.
    set_rom_mode(1'b1);
    push_item(OpLoad,  16'h0000, 8'h96, 1'b0, 15'h3FFF);
    push_item(OpRead,  16'hFFFF, 8'h00, 1'b0, 15'h0000);
    push_item(OpRead,  AddrRomHi, 8'h00, 1'b0, 15'h0000);
    push_item(OpRead,  16'hBFFF, 8'h00, 1'b0, 15'h0000);
    push_item(OpWrite, AddrDmaReg, 8'hC0, 1'b0, 15'h0000);
    push_item(OpWrite, AddrDmaReg, 8'hBF, 1'b1, 15'h0000);
    repeat (500) gen_random(1'b1);
    wait_drained();

    set_rom_mode(1'b0);
    repeat (500) gen_random(1'b0);
    wait_drained();

    // Last part: back to 16 KB, full rate with no gaps.
    set_rom_mode(1'b1);
    gaps_on = 1'b0;
    idle_left = 0;
    repeat (650) gen_random(1'b1);
    wait_drained();

    // Let a stray late result show up before judging.
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
